// ===== src/dtv_pkg.sv =====
package dtv_pkg;

	localparam int LIMIT_W = 21;
	localparam int COUNT_W_DEF = 16;
	localparam int SUM_W_DEF = 41;
	localparam int INT_W = 14;
	localparam int FRAC_W = 7;
	localparam int CFG_INDEX_W = 2;

	localparam logic [INT_W-1:0] INT_CAP = INT_W'(10485);

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAC = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOWER = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_UPPER = 2'd2;

	localparam logic [1:0] MAX_FRAC_RESET = 2'd2;
	localparam logic signed [LIMIT_W-1:0] LOWER_RESET = -21'sd100000;
	localparam logic signed [LIMIT_W-1:0] UPPER_RESET = 21'sd100000;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_INT = 2'd1,
		PH_FRAC = 2'd2
	} phase_t;

endpackage

// ===== src/decimal_token_validator_core.sv =====
// The item carrying tlast is taken into the input register, then passes the token
// summary, value and result registers on its way to m_axis.
// Throughput: one item per cycle; the only stall is back-pressure from m_axis_tready.
// Reset (arst_n low) clears token state, running count and sum, and returns the
// registers to their reset values: two fraction digits, limits -1000.00 and 1000.00.
module decimal_token_validator_core
	import dtv_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_W_DEF,
	parameter int SUM_WIDTH = SUM_W_DEF,
	localparam int OUT_DATA_W = ((LIMIT_W + COUNT_WIDTH + SUM_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // char_code
	input  logic                   s_axis_tlast,  // token_end
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // value_hundredths, legal_count, legal_sum, zeros
	output logic [0:0]             m_axis_tuser,  // is_legal
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]     cfg_data
);

	// Configuration registers
	logic [1:0]                  max_frac_q;
	logic signed [LIMIT_W-1:0]   lower_q;
	logic signed [LIMIT_W-1:0]   upper_q;

	// Input register
	logic                        valid_s1;
	logic [7:0]                  char_s1;
	logic                        last_s1;

	// Token state
	phase_t                      phase_q, phase_d;
	logic                        neg_q, neg_d;
	logic [INT_W-1:0]            int_q, int_d;
	logic [FRAC_W-1:0]           frac_q, frac_d;
	logic [1:0]                  seen_q, seen_d;
	logic                        bad_q, bad_d;

	// Token summary and value stages
	logic                        valid_s2;
	logic                        neg_s2;
	logic                        bad_s2;
	logic [INT_W-1:0]            int_s2;
	logic [FRAC_W-1:0]           frac_s2;
	logic                        valid_s3;
	logic                        bad_s3;
	logic signed [LIMIT_W:0]     val_s3;

	// Result register and accumulators
	logic                        out_valid_q;
	logic                        legal_q;
	logic [LIMIT_W-1:0]          value_q;
	logic [COUNT_WIDTH-1:0]      count_q;
	logic [SUM_WIDTH-1:0]        sum_q;

	logic                        out_free, s3_free, s2_free, s1_adv;
	logic                        is_digit;
	logic [3:0]                  digit;
	logic [1:0]                  max_frac;
	logic [INT_W+2:0]            int_ext, int_grown;
	logic [LIMIT_W-1:0]          mag;
	logic signed [LIMIT_W:0]     val;
	logic                        legal;
	logic [SUM_WIDTH-1:0]        sum_add;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frac_q <= MAX_FRAC_RESET;
			lower_q <= LOWER_RESET;
			upper_q <= UPPER_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_FRAC: max_frac_q <= cfg_data[1:0];
				REG_LOWER: lower_q <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: each stage moves when the one after it is empty or moving.
	// Characters without tlast finish in the parser and never occupy later stages.
	assign out_free = !out_valid_q || m_axis_tready;
	assign s3_free = !valid_s3 || out_free;
	assign s2_free = !valid_s2 || s3_free;
	assign s1_adv = valid_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Parser next state
	assign is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit = is_digit ? char_s1[3:0] : 4'd0;
	assign max_frac = (max_frac_q == 2'd3) ? 2'd2 : max_frac_q;
	assign int_ext = (INT_W+3)'(int_q);
	assign int_grown = (int_ext << 3) + (int_ext << 1) + (INT_W+3)'(digit);

	always_comb begin
		phase_d = phase_q;
		neg_d = neg_q;
		int_d = int_q;
		frac_d = frac_q;
		seen_d = seen_q;
		bad_d = bad_q;
		unique case (phase_q)
			PH_FIRST: begin
				phase_d = PH_INT;
				if (char_s1 == CH_MINUS) begin
					neg_d = 1'b1;
				end else if (char_s1 == CH_POINT) begin
					phase_d = PH_FRAC;
				end else if (is_digit) begin
					if (int_grown > (INT_W+3)'(INT_CAP)) begin
						int_d = INT_CAP;
						bad_d = 1'b1;
					end else begin
						int_d = int_grown[INT_W-1:0];
					end
				end else if (char_s1 != CH_PLUS) begin
					bad_d = 1'b1;
				end
			end
			PH_INT: begin
				if (char_s1 == CH_POINT) begin
					phase_d = PH_FRAC;
				end else if (is_digit) begin
					if (int_grown > (INT_W+3)'(INT_CAP)) begin
						int_d = INT_CAP;
						bad_d = 1'b1;
					end else begin
						int_d = int_grown[INT_W-1:0];
					end
				end else begin
					bad_d = 1'b1;
				end
			end
			PH_FRAC: begin
				if (!is_digit) begin
					bad_d = 1'b1;
				end else if (seen_q >= max_frac) begin
					bad_d = 1'b1;
					if (seen_q != 2'd3) begin
						seen_d = seen_q + 2'd1;
					end
				end else begin
					// The first fraction digit is tenths, the second hundredths.
					frac_d = frac_q + ((seen_q == 2'd0) ? FRAC_W'(digit) * FRAC_W'(10)
						: FRAC_W'(digit));
					seen_d = seen_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			neg_q <= 1'b0;
			int_q <= '0;
			frac_q <= '0;
			seen_q <= '0;
			bad_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				phase_q <= PH_FIRST;
				neg_q <= 1'b0;
				int_q <= '0;
				frac_q <= '0;
				seen_q <= '0;
				bad_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				neg_q <= neg_d;
				int_q <= int_d;
				frac_q <= frac_d;
				seen_q <= seen_d;
				bad_q <= bad_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= s1_adv && last_s1;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && last_s1) begin
			neg_s2 <= neg_d;
			bad_s2 <= bad_d;
			int_s2 <= int_d;
			frac_s2 <= frac_d;
		end
		if (s3_free && valid_s2) begin
			bad_s3 <= bad_s2;
			val_s3 <= val;
		end
	end

	assign mag = LIMIT_W'(int_s2) * LIMIT_W'(100) + LIMIT_W'(frac_s2);
	assign val = neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	assign legal = !bad_s3 && (val_s3 >= $signed({lower_q[LIMIT_W-1], lower_q}))
		&& (val_s3 <= $signed({upper_q[LIMIT_W-1], upper_q}));
	assign sum_add = sum_q + {{(SUM_WIDTH-LIMIT_W-1){val_s3[LIMIT_W]}}, val_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q <= '0;
			sum_q <= '0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
			if (valid_s3 && legal) begin
				if (count_q != {COUNT_WIDTH{1'b1}}) begin
					count_q <= count_q + COUNT_WIDTH'(1);
				end
				sum_q <= sum_add;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			legal_q <= legal;
			value_q <= legal ? val_s3[LIMIT_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = legal_q;
	assign m_axis_tdata = OUT_DATA_W'({sum_q, count_q, value_q});

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("legal count went down");

	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !legal_q |-> value_q == '0)
		else $error("illegal token carries a non-zero value");

	a_legal_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && legal_q |-> count_q != '0)
		else $error("legal token delivered with zero count");

	a_token_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> phase_q == PH_FIRST && !bad_q && int_q == '0)
		else $error("token state not cleared after token end");

	a_int_capped: assert property (@(posedge clk) disable iff (!arst_n)
		int_q <= INT_CAP)
		else $error("integer part above its cap");

endmodule

// ===== test/tb_decimal_token_validator_core.sv =====
module tb_decimal_token_validator_core;
	import dtv_pkg::*;

	localparam int OUT_W = ((LIMIT_W + COUNT_W_DEF + SUM_W_DEF + 7) / 8) * 8;
	localparam int CNT_LSB = LIMIT_W;
	localparam int SUM_LSB = LIMIT_W + COUNT_W_DEF;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} char_item_t;

	typedef struct {
		logic                        legal;
		logic signed [LIMIT_W-1:0]   value;
		logic [COUNT_W_DEF-1:0]      count;
		logic [SUM_W_DEF-1:0]        sum;
	} token_verdict_t;

	typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0] cfg_data = '0;

	char_item_t char_stream[$];
	token_verdict_t token_verdicts[$];
	int mismatches = 0;

	// Copy of the block's registers and token state.
	logic [1:0] cfg_max_frac = MAX_FRAC_RESET;
	logic signed [LIMIT_W-1:0] cfg_lo = LOWER_RESET;
	logic signed [LIMIT_W-1:0] cfg_hi = UPPER_RESET;
	phase_t tok_phase = PH_FIRST;
	bit tok_neg = 1'b0;
	int unsigned tok_int = 0;
	int unsigned tok_frac = 0;
	int unsigned tok_fdigits = 0;
	bit tok_bad = 1'b0;
	logic [COUNT_W_DEF-1:0] legal_total = '0;
	logic [SUM_W_DEF-1:0] legal_acc = '0;

	int tx_gap = 0;
	int tx_burst = 0;
	int rx_hold_len = 0;
	int rx_hold_left = 0;
	int rx_mode_left = 0;
	rx_mode_t rx_mode = RX_STEADY;

	decimal_token_validator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic add_int_digit(input int unsigned d);
		int unsigned n;
		n = tok_int * 10 + d;
		if (n > INT_CAP) begin
			tok_int = INT_CAP;
			tok_bad = 1'b1;
		end else begin
			tok_int = n;
		end
	endtask

	task automatic absorb_char(input logic [7:0] c, input logic last);
		bit is_digit;
		int unsigned d;
		int unsigned frac_cap;
		longint mag;
		longint val;
		bit legal;
		token_verdict_t res;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? int'(c) - int'(CH_ZERO) : 0;
		frac_cap = (cfg_max_frac > 2) ? 2 : cfg_max_frac;
		case (tok_phase)
			PH_FIRST: begin
				if (c == CH_MINUS) begin
					tok_neg = 1'b1;
					tok_phase = PH_INT;
				end else if (c == CH_PLUS) begin
					tok_phase = PH_INT;
				end else if (c == CH_POINT) begin
					tok_phase = PH_FRAC;
				end else begin
					if (is_digit) add_int_digit(d);
					else tok_bad = 1'b1;
					tok_phase = PH_INT;
				end
			end
			PH_INT: begin
				if (c == CH_POINT) tok_phase = PH_FRAC;
				else if (is_digit) add_int_digit(d);
				else tok_bad = 1'b1;
			end
			default: begin
				if (!is_digit) begin
					tok_bad = 1'b1;
				end else if (tok_fdigits >= frac_cap) begin
					tok_bad = 1'b1;
					if (tok_fdigits < 3) tok_fdigits++;
				end else begin
					tok_frac += (tok_fdigits == 0) ? d * 10 : d;
					tok_fdigits++;
				end
			end
		endcase
		if (last) begin
			mag = longint'(tok_int) * 100 + longint'(tok_frac);
			val = tok_neg ? -mag : mag;
			legal = !tok_bad && val >= longint'(cfg_lo) && val <= longint'(cfg_hi);
			if (legal) begin
				if (legal_total != '1) legal_total++;
				legal_acc = legal_acc + SUM_W_DEF'(val);
			end else begin
				val = 0;
			end
			res.legal = legal;
			res.value = LIMIT_W'(val);
			res.count = legal_total;
			res.sum = legal_acc;
			token_verdicts.insert(token_verdicts.size(), res);
			tok_phase = PH_FIRST;
			tok_neg = 1'b0;
			tok_int = 0;
			tok_frac = 0;
			tok_fdigits = 0;
			tok_bad = 1'b0;
		end
	endtask

	// Results are checked before the item of the same edge is predicted; the
	// latency rules out a result belonging to an item accepted at that edge.
	always @(posedge clk) begin : check_and_predict
		token_verdict_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (token_verdicts.size() == 0) begin
					flag_mismatch("unexpected result", 64'(m_axis_tdata[LIMIT_W-1:0]), 64'd0);
				end else begin
					want = token_verdicts.pop_front();
					if (m_axis_tuser[0] !== want.legal)
						flag_mismatch("is_legal", 64'(m_axis_tuser[0]), 64'(want.legal));
					if (m_axis_tdata[0 +: LIMIT_W] !== want.value)
						flag_mismatch("value", 64'(m_axis_tdata[0 +: LIMIT_W]),
							64'(want.value));
					if (m_axis_tdata[CNT_LSB +: COUNT_W_DEF] !== want.count)
						flag_mismatch("count", 64'(m_axis_tdata[CNT_LSB +: COUNT_W_DEF]),
							64'(want.count));
					if (m_axis_tdata[SUM_LSB +: SUM_W_DEF] !== want.sum)
						flag_mismatch("sum", 64'(m_axis_tdata[SUM_LSB +: SUM_W_DEF]),
							64'(want.sum));
				end
			end
			if (s_axis_tvalid && s_axis_tready) absorb_char(s_axis_tdata, s_axis_tlast);
		end
	end

	always @(posedge clk) begin : tx_drive
		char_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap > 0 || char_stream.size() == 0) begin
				if (tx_gap > 0) tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else begin
				nxt = char_stream.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nxt.code;
				s_axis_tlast <= nxt.last;
				if (tx_burst > 0) begin
					tx_burst--;
				end else begin
					tx_burst = $urandom_range(0, 24);
					tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	always @(posedge clk) begin : rx_drive
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_hold_len != 0) begin
				rx_hold_left = rx_hold_len;
				rx_hold_len <= 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(10, 80);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					RX_STEADY: m_axis_tready <= 1'b1;
					RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	task automatic push_char(input logic [7:0] code, input logic last);
		char_item_t it;
		it.code = code;
		it.last = last;
		char_stream.insert(char_stream.size(), it);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
	endtask

	// Mostly well-formed tokens with random digits; the rest are tokens with one
	// character spoilt, or plain noise.
	task automatic queue_random_token(output int len);
		string alphabet;
		logic [7:0] tok[$];
		int kind;
		int n_int;
		int n_frac;
		int r;
		alphabet = "+-.0123456789";
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			r = $urandom_range(0, 3);
			if (r == 0) tok.insert(tok.size(), CH_MINUS);
			else if (r == 1) tok.insert(tok.size(), CH_PLUS);
			n_int = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			for (int i = 0; i < n_int; i++)
				tok.insert(tok.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
			if ($urandom_range(0, 2) != 0) begin
				tok.insert(tok.size(), CH_POINT);
				n_frac = $urandom_range(0, 3);
				for (int i = 0; i < n_frac; i++)
					tok.insert(tok.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
			end
			if (tok.size() == 0) tok.insert(tok.size(), CH_ZERO);
			if (kind >= 70) tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			n_int = $urandom_range(1, 5);
			for (int i = 0; i < n_int; i++) begin
				if ($urandom_range(0, 1) == 0)
					tok.insert(tok.size(), 8'($urandom_range(0, 255)));
				else
					tok.insert(tok.size(), alphabet[$urandom_range(0, alphabet.len() - 1)]);
			end
		end
		len = tok.size();
		for (int i = 0; i < len; i++) push_char(tok[i], i == len - 1);
	endtask

	task automatic add_random_chars(input int n);
		int done;
		int len;
		done = 0;
		while (done < n) begin
			queue_random_token(len);
			done += len;
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_FRAC: cfg_max_frac = data[1:0];
			REG_LOWER: cfg_lo = data;
			REG_UPPER: cfg_hi = data;
			default: ;
		endcase
	endtask

	// Waits until everything queued has been sent and every result has come out of the block.
	task automatic settle();
		while (char_stream.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (token_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin : stimulus
		int mf;
		int lo;
		int hi;
		int t;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_text("0");
		push_text("+");
		push_text(".");
		push_text("-.");
		push_text("1.5");
		push_text("-3.25");
		push_text("4.567");
		push_text("5-");
		push_text("..");
		push_text("11111");
		push_text("999.99");
		push_char(8'h00, 1'b1);
		push_char(8'hFF, 1'b1);
		add_random_chars(150);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					mf = 0;
					lo = -1000000;
					hi = 1000000;
				end
				1: begin
					mf = 1;
					lo = -1000;
					hi = 1000;
				end
				2: begin
					// Crossed limits: nothing can be legal.
					mf = 3;
					lo = 500;
					hi = -500;
				end
				3: begin
					mf = 2;
					lo = 0;
					hi = 0;
				end
				default: begin
					mf = $urandom_range(0, 3);
					lo = -$urandom_range(0, 1000000);
					hi = $urandom_range(0, 1000000);
					if ($urandom_range(0, 4) == 0) begin
						t = lo;
						lo = hi;
						hi = t;
					end
				end
			endcase
			write_reg(REG_MAX_FRAC, {19'($urandom), 2'(mf)});
			write_reg(REG_LOWER, LIMIT_W'(lo));
			write_reg(REG_UPPER, LIMIT_W'(hi));
			add_random_chars(220);
			// A long receiver stall while the sender keeps offering items.
			if (ph == 1) rx_hold_len <= 400;
			settle();
		end

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule
